// ===== hw/rtl/mts_pkg.sv =====
// ============================================================================
// mts_pkg
// Shared types and codes for the max-tracking stack.
// ============================================================================
package mts_pkg;

    // Request codes
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 9;

    // One stack entry: value and running max of it and everything below
    typedef struct packed {
        logic signed [VALUE_W-1:0] max;
        logic signed [VALUE_W-1:0] value;
    } t_entry;

    // Shift command broadcast to every cell
    typedef struct packed {
        logic push;   // shift toward the bottom, load from above
        logic pop;    // shift toward the top, load from below
    } t_shift_ctrl;

endpackage

// ===== hw/rtl/mts_cell.sv =====
// ============================================================================
// mts_cell
// One stack slot: holds an entry, loads from its upper or lower neighbor.
// ============================================================================
module mts_cell (
    input  logic                 i_clk,
    input  mts_pkg::t_shift_ctrl i_ctrl,
    input  mts_pkg::t_entry      i_from_above,
    input  mts_pkg::t_entry      i_from_below,
    output mts_pkg::t_entry      o_entry
);

    mts_pkg::t_entry r_entry;
    mts_pkg::t_entry n_entry;

    always_comb begin
        priority if (i_ctrl.push) begin
            n_entry = i_from_above;
        end else if (i_ctrl.pop) begin
            n_entry = i_from_below;
        end else begin
            n_entry = r_entry;
        end
    end

    // payload only, no reset: slots past the count are never observed
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== hw/rtl/max_tracking_stack.sv =====
// ============================================================================
// max_tracking_stack
// LIFO of signed 32-bit values that also reports the largest value held.
// ============================================================================
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+---------------------------
//  req     | in        | i_req_valid / o_req_ready    | i_req_type, i_push_value
//  rsp     | out       | o_rsp_valid / i_rsp_ready    | o_top_value, o_current_max,
//          |           |                              | o_entry_count, o_is_empty,
//          |           |                              | o_status
//
//  One transfer per cycle: a request is answered in the cycle after it is taken.
//  The entries live in a row of STACK_DEPTH cells, cell 0 being the top; a push
//  shifts the whole row one cell down, a pop one cell up.
//  The response register frees in the same cycle that its transfer completes,
//  so requests stall only while a response waits with i_rsp_ready low.
//  Synchronous active-low reset empties the stack; no clearing pass is needed.
//
module max_tracking_stack #(
    parameter int unsigned STACK_DEPTH = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  logic                 i_req_type,
    input  logic signed [31:0]   i_push_value,

    output logic                 o_rsp_valid,
    input  logic                 i_rsp_ready,
    output logic signed [31:0]   o_top_value,
    output logic signed [31:0]   o_current_max,
    output logic [8:0]           o_entry_count,
    output logic                 o_is_empty,
    output logic [1:0]           o_status
);

    localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

    // ---- control state ----
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_rsp_valid;

    // ---- response payload ----
    mts_pkg::t_entry  r_rsp_entry;
    mts_pkg::t_entry  n_rsp_entry;
    logic [CNT_W-1:0] r_rsp_count;
    logic             r_rsp_empty;
    logic             n_rsp_empty;
    logic [1:0]       r_rsp_status;
    logic [1:0]       n_rsp_status;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    mts_pkg::t_entry  w_new_entry;
    mts_pkg::t_shift_ctrl w_ctrl;

    // cell outputs; index 0 is the top of stack
    mts_pkg::t_entry  w_cell [STACK_DEPTH];

    assign o_req_ready = !r_rsp_valid || i_rsp_ready;
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_full      = (r_count == CNT_W'(STACK_DEPTH));
    assign w_empty     = (r_count == '0);

    // new top: running max folds in the previous top's max (signed)
    always_comb begin
        w_new_entry.value = i_push_value;
        if (!w_empty && (w_cell[0].max > i_push_value)) begin
            w_new_entry.max = w_cell[0].max;
        end else begin
            w_new_entry.max = i_push_value;
        end
    end

    // shift only on operations that change the stack
    always_comb begin
        w_ctrl.push = w_accept && (i_req_type == mts_pkg::REQ_PUSH) && !w_full;
        w_ctrl.pop  = w_accept && (i_req_type == mts_pkg::REQ_POP) && !w_empty;
    end

    // ---- row of cells ----
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        mts_pkg::t_entry w_above;
        mts_pkg::t_entry w_below;

        if (g == 0) begin : g_top
            assign w_above = w_new_entry;
        end else begin : g_mid
            assign w_above = w_cell[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_bot
            assign w_below = w_cell[g];     // bottom slot has nothing below
        end else begin : g_up
            assign w_below = w_cell[g+1];
        end

        mts_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_entry      (w_cell[g])
        );
    end

    // ---- next count, status and post-operation view ----
    always_comb begin
        n_count      = r_count;
        n_rsp_status = mts_pkg::STATUS_OK;
        n_rsp_entry  = w_cell[0];
        if (i_req_type == mts_pkg::REQ_PUSH) begin
            if (w_full) begin
                n_rsp_status = mts_pkg::STATUS_OVERFLOW;
            end else begin
                n_count     = r_count + 1'b1;
                n_rsp_entry = w_new_entry;
            end
        end else begin
            if (w_empty) begin
                n_rsp_status = mts_pkg::STATUS_UNDERFLOW;
            end else begin
                n_count     = r_count - 1'b1;
                n_rsp_entry = w_cell[1];
            end
        end
        n_rsp_empty = (n_count == '0);
        if (n_rsp_empty) begin
            n_rsp_entry = '0;   // empty stack reports zero top and max
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp_entry  <= n_rsp_entry;
            r_rsp_count  <= n_count;
            r_rsp_empty  <= n_rsp_empty;
            r_rsp_status <= n_rsp_status;
        end
    end

    assign o_rsp_valid   = r_rsp_valid;
    assign o_top_value   = r_rsp_entry.value;
    assign o_current_max = r_rsp_entry.max;
    assign o_entry_count = 9'(r_rsp_count);   // count reported modulo 512
    assign o_is_empty    = r_rsp_empty;
    assign o_status      = r_rsp_status;

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_overflow_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_req_type == mts_pkg::REQ_PUSH) && w_full |=> $stable(r_count))
        else $error("rejected push changed the count");

    a_rsp_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_rsp_valid)
        else $error("accepted request produced no response");

    a_empty_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_is_empty |-> (o_top_value == '0) && (o_current_max == '0))
        else $error("empty response carries nonzero data");

    a_max_covers_top : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_is_empty |-> o_current_max >= o_top_value)
        else $error("reported max below top value");
`endif

endmodule
